// ===== src/dfhe_pkg.sv =====
// ----------------------------------------------------------------------------
// dfhe_pkg
// Shared types and constants for the fixed-Huffman DEFLATE encoder.
// ----------------------------------------------------------------------------
package dfhe_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LIT   = 2'd1;
  localparam logic [1:0] KIND_MATCH = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam int TOK_BITS_W  = 31;
  localparam int TOK_CNT_W   = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [TOK_BITS_W-1:0] bits;
    logic [TOK_CNT_W-1:0]  n;
    logic                  flush;
  } tok_t;

endpackage

// ===== src/deflate_fixed_huffman_encoder.sv =====
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_encoder
// Packs a token stream into a DEFLATE fixed-Huffman block, byte by byte.
// ----------------------------------------------------------------------------
// The encoder takes one token per cycle into a short queue while the queue
// has room; the packer then sends the bytes of each token in turn, and a
// token that completes no byte passes through the packer with no output.
// The output byte port sets the sustained rate at one byte per cycle while
// m_axis_tready is held high.
module deflate_fixed_huffman_encoder #(
  parameter int QUEUE_DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // literal_byte, match_length, match_distance
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // last
  output logic [0:0]  m_axis_tuser    // stream_end
);

  dfhe_pkg::tok_t enc_tok;
  dfhe_pkg::tok_t head_tok;
  logic           q_full;
  logic           head_valid;
  logic           pop;
  logic           unused_pad;

  assign s_axis_tready = !q_full;
  assign unused_pad    = ^s_axis_tdata[39:33];

  dfhe_front u_front (
    .kind           (s_axis_tuser),
    .literal_byte   (s_axis_tdata[7:0]),
    .match_length   (s_axis_tdata[16:8]),
    .match_distance (s_axis_tdata[32:17]),
    .tok            (enc_tok)
  );

  dfhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid),
    .push_tok   (enc_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  dfhe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_tok      (head_tok),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== src/dfhe_queue.sv =====
// ----------------------------------------------------------------------------
// dfhe_queue
// Small register queue of encoded tokens between the encoder and the packer.
// ----------------------------------------------------------------------------
module dfhe_queue #(
  parameter int DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfhe_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dfhe_pkg::tok_t head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dfhe_pkg::tok_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_tok   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/dfhe_front.sv =====
// ----------------------------------------------------------------------------
// dfhe_front
// Token encoder: turns one token into its code bits, in stream order.
// ----------------------------------------------------------------------------
module dfhe_front (
  input  logic [1:0]     kind,
  input  logic [7:0]     literal_byte,
  input  logic [8:0]     match_length,
  input  logic [15:0]    match_distance,
  output dfhe_pkg::tok_t tok
);

  function automatic logic [8:0] rev_bits(input logic [8:0] v, input logic [3:0] w);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      if (4'(i) < w) begin
        r[i] = v[w - 4'(i) - 4'd1];
      end
    end
    return r;
  endfunction

  logic [8:0]  lenc;
  logic [15:0] distc;
  logic [7:0]  l;
  logic [2:0]  lp;
  logic [2:0]  le;
  logic [8:0]  lcode;
  logic [7:0]  lext;
  logic [8:0]  lhuff;
  logic [3:0]  nl;
  logic [14:0] d;
  logic [3:0]  dp;
  logic [3:0]  de;
  logic [4:0]  dcode;
  logic [14:0] dext;
  logic [4:0]  pos1;
  logic [4:0]  pos2;
  logic [4:0]  pos3;
  logic [8:0]  lit9;

  always_comb begin
    lenc = match_length;
    if (match_length < 9'd3) begin
      lenc = 9'd3;
    end else if (match_length > 9'd258) begin
      lenc = 9'd258;
    end
    distc = match_distance;
    if (match_distance == 16'd0) begin
      distc = 16'd1;
    end else if (match_distance > 16'd32768) begin
      distc = 16'd32768;
    end

    l  = 8'(lenc - 9'd3);
    lp = 3'd3;
    for (int i = 3; i < 8; i++) begin
      if (l[i]) begin
        lp = 3'(i);
      end
    end
    if (lenc == 9'd258) begin
      lcode = 9'd285;
      le    = 3'd0;
      lext  = 8'd0;
    end else if (l < 8'd8) begin
      lcode = 9'd257 + {1'b0, l};
      le    = 3'd0;
      lext  = 8'd0;
    end else begin
      le    = lp - 3'd2;
      lcode = 9'd257 + {4'b0, lp - 3'd1, 2'b00} + {7'b0, 2'(l >> le)};
      lext  = l & ((8'd1 << le) - 8'd1);
    end
    if (lcode < 9'd280) begin
      lhuff = rev_bits(9'(lcode - 9'd256), 4'd7);
      nl    = 4'd7;
    end else begin
      lhuff = rev_bits(9'(lcode - 9'd88), 4'd8);
      nl    = 4'd8;
    end

    d  = 15'(distc - 16'd1);
    dp = 4'd2;
    for (int i = 2; i < 15; i++) begin
      if (d[i]) begin
        dp = 4'(i);
      end
    end
    if (d < 15'd4) begin
      dcode = 5'(d);
      de    = 4'd0;
      dext  = 15'd0;
    end else begin
      dcode = {dp, 1'b0} + {4'b0, d[dp - 4'd1]};
      de    = dp - 4'd1;
      dext  = d & ((15'd1 << de) - 15'd1);
    end

    pos1 = {1'b0, nl};
    pos2 = pos1 + {2'b0, le};
    pos3 = pos2 + 5'd5;

    lit9 = {1'b0, literal_byte} + 9'h190 - 9'd144;

    tok = '0;
    unique case (kind)
      dfhe_pkg::KIND_START: begin
        tok.bits = 31'd3;
        tok.n    = 5'd3;
      end
      dfhe_pkg::KIND_LIT: begin
        if (literal_byte < 8'd144) begin
          tok.bits = 31'(rev_bits(9'({1'b0, literal_byte} + 9'h030), 4'd8));
          tok.n    = 5'd8;
        end else begin
          tok.bits = 31'(rev_bits(lit9, 4'd9));
          tok.n    = 5'd9;
        end
      end
      dfhe_pkg::KIND_MATCH: begin
        tok.bits = 31'(lhuff)
                 | (31'(lext) << pos1)
                 | (31'(rev_bits({4'b0, dcode}, 4'd5)) << pos2)
                 | (31'(dext) << pos3);
        tok.n    = pos3 + {1'b0, de};
      end
      dfhe_pkg::KIND_END: begin
        tok.bits  = '0;
        tok.n     = 5'd7;
        tok.flush = 1'b1;
      end
      default: begin
        tok = '0;
      end
    endcase
  end

endmodule

// ===== src/dfhe_back.sv =====
// ----------------------------------------------------------------------------
// dfhe_back
// Bit packer: merges token bits with the pending partial byte and sends
// completed bytes one per cycle unless stalled, via an output register.
// ----------------------------------------------------------------------------
module dfhe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  dfhe_pkg::tok_t head_tok,
  output logic           pop,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // out_byte
  output logic           m_axis_tlast,
  output logic [0:0]     m_axis_tuser    // stream_end
);

  localparam int WW = dfhe_pkg::TOK_BITS_W + 7;

  logic [WW-1:0] wbits;
  logic [5:0]    wn;
  logic          wflush;
  logic          active;

  logic          emit_ok;
  logic          has_byte;
  logic          fire;
  logic [WW-1:0] rem_bits;
  logic [5:0]    rem_n;
  logic          done_after;
  logic          item_done;
  logic [6:0]    acc_bits;
  logic [2:0]    acc_n;

  always_comb begin
    emit_ok    = !m_axis_tvalid || m_axis_tready;
    has_byte   = active && ((wn >= 6'd8) || (wflush && wn != 6'd0));
    fire       = has_byte && emit_ok;
    rem_bits   = fire ? (wbits >> 8) : wbits;
    rem_n      = fire ? ((wn >= 6'd8) ? wn - 6'd8 : 6'd0) : wn;
    done_after = !((rem_n >= 6'd8) || (wflush && rem_n != 6'd0));
    item_done  = active && done_after;
    acc_bits   = wflush ? 7'd0 : rem_bits[6:0];
    acc_n      = wflush ? 3'd0 : rem_n[2:0];
    pop        = (!active || item_done) && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wbits  <= '0;
      wn     <= '0;
      wflush <= 1'b0;
      active <= 1'b0;
    end else if (pop) begin
      wbits  <= WW'(acc_bits) | (WW'(head_tok.bits) << acc_n);
      wn     <= 6'(acc_n) + 6'(head_tok.n);
      wflush <= head_tok.flush;
      active <= 1'b1;
    end else if (item_done) begin
      wbits  <= WW'(acc_bits);
      wn     <= 6'(acc_n);
      wflush <= 1'b0;
      active <= 1'b0;
    end else if (fire) begin
      wbits <= rem_bits;
      wn    <= rem_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= wbits[7:0];
      m_axis_tlast <= done_after;
      m_axis_tuser <= done_after && wflush;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives token streams into the fixed-Huffman DEFLATE encoder and checks
// every packed output byte, with its last and stream_end flags, against a
// bit-accurate encoding of the same tokens worked out inside the bench.
// Four phases cover free flow, sparse input, heavy output stalls and light
// idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [15:0] distance;
  } token_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       stream_end;
  } packed_byte_t;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_mode_t;

  localparam int LIMIT = 200000;

  localparam int LEN_BASE [6] = '{3, 11, 19, 35, 67, 131};
  localparam int LEN_CODE [6] = '{257, 265, 269, 273, 277, 281};
  localparam int DIST_BASE [14] = '{1, 5, 9, 17, 33, 65, 129, 257, 513, 1025, 2049,
                                    4097, 8193, 16385};
  localparam int DIST_CODE [14] = '{0, 4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26, 28};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  token_t       token_q [$];
  packed_byte_t byte_q [$];
  token_t       drv_token;
  packed_byte_t got;
  idle_mode_t   idle_mode = PH_FREE;
  int           errors = 0;
  int           cycle_count = 0;

  logic [6:0]   acc_bits = '0;
  int           acc_count = 0;
  logic [63:0]  pend_bits;
  int           pend_n;

  deflate_fixed_huffman_encoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void put_lsb(int val, int nbits);
    logic [63:0] masked;
    masked = 64'(val) & ((64'd1 << nbits) - 64'd1);
    pend_bits = pend_bits | (masked << pend_n);
    pend_n = pend_n + nbits;
  endfunction

  function automatic void put_msb(int val, int nbits);
    int rev;
    rev = 0;
    for (int i = 0; i < nbits; i++)
      rev = rev | (((val >> (nbits - 1 - i)) & 1) << i);
    put_lsb(rev, nbits);
  endfunction

  // Appends the bytes that one token completes to the expected byte store.
  function automatic void encode_token(token_t t);
    packed_byte_t outs [$];
    packed_byte_t pb;
    int len, distance, b, rel;
    pend_bits = 64'(acc_bits);
    pend_n = acc_count;
    case (t.kind)
      dfhe_pkg::KIND_START: put_lsb(3, 3);
      dfhe_pkg::KIND_LIT: begin
        if (t.lit < 144) put_msb(32'h30 + t.lit, 8);
        else put_msb(32'h190 + (t.lit - 144), 9);
      end
      dfhe_pkg::KIND_MATCH: begin
        len = t.len;
        distance = t.distance;
        if (len < 3) len = 3;
        if (len > 258) len = 258;
        if (distance < 1) distance = 1;
        if (distance > 32768) distance = 32768;
        if (len == 258) begin
          put_msb(285 - 280 + 192, 8);
        end else begin
          b = 5;
          while (b > 0 && len < LEN_BASE[b]) b--;
          rel = len - LEN_BASE[b];
          if (LEN_CODE[b] + (rel >> b) < 280) put_msb(LEN_CODE[b] + (rel >> b) - 256, 7);
          else put_msb(LEN_CODE[b] + (rel >> b) - 280 + 192, 8);
          if (b > 0) put_lsb(rel & ((1 << b) - 1), b);
        end
        b = 13;
        while (b > 0 && distance < DIST_BASE[b]) b--;
        rel = distance - DIST_BASE[b];
        put_msb(DIST_CODE[b] + (rel >> b), 5);
        if (b > 0) put_lsb(rel & ((1 << b) - 1), b);
      end
      default: put_msb(0, 7);
    endcase
    while (pend_n >= 8) begin
      pb.data = pend_bits[7:0];
      pb.last = 1'b0;
      pb.stream_end = 1'b0;
      outs.push_back(pb);
      pend_bits = pend_bits >> 8;
      pend_n = pend_n - 8;
    end
    if (t.kind == dfhe_pkg::KIND_END) begin
      if (pend_n > 0) begin
        pb.data = pend_bits[7:0];
        pb.last = 1'b0;
        pb.stream_end = 1'b0;
        outs.push_back(pb);
      end
      pend_bits = '0;
      pend_n = 0;
      outs[outs.size() - 1].stream_end = 1'b1;
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) byte_q.push_back(outs[i]);
    acc_bits = pend_bits[6:0];
    acc_count = pend_n;
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      PH_SEND_IDLE: return $urandom_range(99) < 81;
      PH_BOTH:      return $urandom_range(99) < 15;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      PH_RECV_STALL: return $urandom_range(99) < 81;
      PH_BOTH:       return $urandom_range(99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) encode_token(drv_token);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (token_q.size() > 0 && !send_gap()) begin
          drv_token = token_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, drv_token.distance, drv_token.len, drv_token.lit};
          s_axis_tuser <= drv_token.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (byte_q.size() == 0) begin
          $error("unexpected output byte 0x%02h", m_axis_tdata);
          errors++;
        end else begin
          got = byte_q.pop_front();
          if (m_axis_tdata !== got.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", got.data, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== got.last) begin
            $error("last: expected %0b, got %0b", got.last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser[0] !== got.stream_end) begin
            $error("stream_end: expected %0b, got %0b", got.stream_end, m_axis_tuser[0]);
            errors++;
          end
        end
      end
      m_axis_tready <= !recv_stall();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic token_t make_token(logic [1:0] kind, int lit, int len, int distance);
    token_t t;
    t.kind = kind;
    t.lit = 8'(lit);
    t.len = 9'(len);
    t.distance = 16'(distance);
    return t;
  endfunction

  function automatic token_t random_token(logic [1:0] kind);
    int len, distance;
    if ($urandom_range(9) < 8) len = $urandom_range(258, 3);
    else len = $urandom_range(511);
    case ($urandom_range(9))
      0:       distance = $urandom_range(65535);
      1:       distance = $urandom_range(32768, 16385);
      default: distance = $urandom_range(1 << $urandom_range(14, 1), 1);
    endcase
    return make_token(kind, $urandom_range(255), len, distance);
  endfunction

  task automatic drain();
    while (token_q.size() > 0 || s_axis_tvalid) @(negedge clk);
    while (byte_q.size() > 0) @(negedge clk);
  endtask

  initial begin
    int count;
    int body;
    @(posedge clk);
    while (rst) @(posedge clk);

    token_q.push_back(make_token(dfhe_pkg::KIND_START, 255, 511, 65535));
    token_q.push_back(make_token(dfhe_pkg::KIND_LIT, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_LIT, 143, 511, 65535));
    token_q.push_back(make_token(dfhe_pkg::KIND_LIT, 144, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_LIT, 255, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 3, 1));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 255, 258, 32768));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 257, 16385));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 10, 4));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 11, 5));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 511, 65535));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 259, 32769));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 130, 16384));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 227, 24577));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 0, 2, 24576));
    token_q.push_back(make_token(dfhe_pkg::KIND_END, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_END, 255, 511, 65535));
    token_q.push_back(make_token(dfhe_pkg::KIND_START, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_START, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_START, 0, 0, 0));
    token_q.push_back(make_token(dfhe_pkg::KIND_LIT, 200, 511, 65535));
    token_q.push_back(make_token(dfhe_pkg::KIND_MATCH, 170, 131, 32767));
    token_q.push_back(make_token(dfhe_pkg::KIND_END, 170, 341, 43690));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      count = 0;
      while (count < 32) begin
        if ($urandom_range(9) == 0) begin
          token_q.push_back(random_token(2'($urandom_range(3))));
          count++;
        end else begin
          token_q.push_back(random_token(dfhe_pkg::KIND_START));
          body = $urandom_range(8, 1);
          for (int i = 0; i < body; i++)
            token_q.push_back(random_token($urandom_range(2) == 0 ?
                                           dfhe_pkg::KIND_MATCH : dfhe_pkg::KIND_LIT));
          token_q.push_back(random_token(dfhe_pkg::KIND_END));
          count += body + 2;
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && byte_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dfhe_pkg.sv
src/dfhe_queue.sv
src/dfhe_front.sv
src/dfhe_back.sv
src/deflate_fixed_huffman_encoder.sv
bench/tb_top.sv
